// ----- hdl/gbs_pkg.sv -----
// ============================================================================
// gbs_pkg: shared types and constants for the greedy box suppression core
// Field widths, store depth, the token that walks the cell chain, and the
// per-cell control bundle.
// ============================================================================
package gbs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int CNT_W      = $clog2(MAX_KEPT + 1);
    // Comparison stages that trail a cell's own overlap step.
    localparam int TAIL_CELLS = 3;
    localparam int CHAIN_LEN  = MAX_KEPT + TAIL_CELLS;

    localparam int COORD_W = 13;
    localparam int DIM_W   = 12;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int SUM_W   = AREA_W + 1;
    localparam int THR_W   = 16;
    localparam int PROD_W  = THR_W + SUM_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd13107;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [DIM_W-1:0]   width;
        logic        [DIM_W-1:0]   height;
    } box_t;

    // Candidate box plus the partial results of the three cells behind it.
    typedef struct packed {
        logic              live;
        logic              sup;
        box_t              cand;
        logic [AREA_W-1:0] cand_area;
        logic              s1_vld;
        logic [DIM_W-1:0]  s1_dx;
        logic [DIM_W-1:0]  s1_dy;
        logic [AREA_W-1:0] s1_karea;
        logic              s2_vld;
        logic [AREA_W-1:0] s2_inter;
        logic [SUM_W-1:0]  s2_sum;
        logic              s3_vld;
        logic [AREA_W-1:0] s3_inter;
        logic [PROD_W-1:0] s3_prod;
    } token_t;

    typedef struct packed {
        logic cmp_en;
        logic load;
    } cell_ctrl_t;

endpackage

// ----- hdl/gbs_ifs.sv -----
// ============================================================================
// gbs_ifs: channel interfaces of the greedy box suppression core
// Box input channel, result channel and threshold write channel.
// ============================================================================
interface gbs_box_if;
    logic                                valid;
    logic                                ready;
    logic                                set_start;
    logic signed [gbs_pkg::COORD_W-1:0]  box_left;
    logic signed [gbs_pkg::COORD_W-1:0]  box_top;
    logic        [gbs_pkg::DIM_W-1:0]    box_width;
    logic        [gbs_pkg::DIM_W-1:0]    box_height;

    modport source (output valid, set_start, box_left, box_top, box_width, box_height,
                    input ready);
    modport sink   (input valid, set_start, box_left, box_top, box_width, box_height,
                    output ready);
endinterface

interface gbs_res_if;
    logic valid;
    logic ready;
    logic keep;
    logic store_overflow;

    modport source (output valid, keep, store_overflow, input ready);
    modport sink   (input valid, keep, store_overflow, output ready);
endinterface

interface gbs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::THR_W-1:0]   iou_threshold;

    modport source (output valid, iou_threshold, input ready);
    modport sink   (input valid, iou_threshold, output ready);
endinterface

// ----- hdl/gbs_cell.sv -----
// ============================================================================
// gbs_cell: one cell of the suppression chain
// Holds one kept box, computes its overlap with the passing candidate, and
// advances the multiply and compare steps of the three cells upstream.
// ============================================================================
module gbs_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  gbs_pkg::cell_ctrl_t         ctrl,
    input  gbs_pkg::box_t               load_box,
    input  logic [gbs_pkg::AREA_W-1:0]  load_area,
    input  logic [gbs_pkg::THR_W-1:0]   thr,
    input  gbs_pkg::token_t             tok_in,
    output gbs_pkg::token_t             tok_out
);
    import gbs_pkg::*;

    box_t              box_reg;
    logic [AREA_W-1:0] area_reg;
    token_t            tok_reg;
    token_t            tok_next;

    logic signed [COORD_W:0] a_l, a_r, b_l, b_r, a_t, a_b, b_t, b_b;
    logic signed [COORD_W:0] x1, x2, y1, y2;
    logic signed [COORD_W+1:0] dx_s, dy_s;
    logic [SUM_W-1:0]  uni;
    logic [PROD_W-1:0] inter_sh;

    always_comb
    begin
        a_l = {tok_in.cand.left[COORD_W-1], tok_in.cand.left};
        a_t = {tok_in.cand.top[COORD_W-1], tok_in.cand.top};
        b_l = {box_reg.left[COORD_W-1], box_reg.left};
        b_t = {box_reg.top[COORD_W-1], box_reg.top};
        a_r = a_l + $signed({2'b00, tok_in.cand.width});
        a_b = a_t + $signed({2'b00, tok_in.cand.height});
        b_r = b_l + $signed({2'b00, box_reg.width});
        b_b = b_t + $signed({2'b00, box_reg.height});
        x1 = (a_l > b_l) ? a_l : b_l;
        y1 = (a_t > b_t) ? a_t : b_t;
        x2 = (a_r < b_r) ? a_r : b_r;
        y2 = (a_b < b_b) ? a_b : b_b;
        dx_s = {x2[COORD_W], x2} - {x1[COORD_W], x1};
        dy_s = {y2[COORD_W], y2} - {y1[COORD_W], y1};

        uni      = tok_in.s2_sum - {1'b0, tok_in.s2_inter};
        inter_sh = {1'b0, tok_in.s3_inter, 16'h0000};

        tok_next           = tok_in;
        tok_next.s1_vld    = tok_in.live && ctrl.cmp_en;
        // The overlap width never exceeds either box width, so it fits DIM_W.
        tok_next.s1_dx     = (dx_s > 0) ? dx_s[DIM_W-1:0] : '0;
        tok_next.s1_dy     = (dy_s > 0) ? dy_s[DIM_W-1:0] : '0;
        tok_next.s1_karea  = area_reg;
        tok_next.s2_vld    = tok_in.s1_vld;
        tok_next.s2_inter  = {{DIM_W{1'b0}}, tok_in.s1_dx} * {{DIM_W{1'b0}}, tok_in.s1_dy};
        tok_next.s2_sum    = {1'b0, tok_in.cand_area} + {1'b0, tok_in.s1_karea};
        tok_next.s3_vld    = tok_in.s2_vld;
        tok_next.s3_inter  = tok_in.s2_inter;
        tok_next.s3_prod   = {{SUM_W{1'b0}}, thr} * {{THR_W{1'b0}}, uni};
        tok_next.sup       = tok_in.sup || (tok_in.s3_vld && (inter_sh > tok_in.s3_prod));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            box_reg  <= load_box;
            area_reg <= load_area;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hdl/greedy_box_suppression_core.sv -----
// ============================================================================
// greedy_box_suppression_core: greedy IoU suppression in arrival order
// Top level: entry register, chain of box cells, kept count and result stage.
// ============================================================================
// Each accepted box walks a chain of MAX_KEPT + 3 cells, one cell per cycle
// while the chain is not stalled; each of the first MAX_KEPT cells holds one
// kept box and the three trailing cells finish the multiply and compare
// steps of the last stored boxes. The next box is accepted only once the
// current box has left the end of the chain. A result waiting in the output
// register does not block the next box; only a second result reaching the
// end of the chain while the first is still waiting stalls the chain. The
// threshold port is always ready.
module greedy_box_suppression_core (
    input logic      clk,
    input logic      rst_n,
    gbs_box_if.sink  box_in,
    gbs_res_if.source result,
    gbs_cfg_if.sink  cfg
);
    import gbs_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [THR_W-1:0] thr_reg;
    token_t           entry_reg, entry_next;
    logic             out_valid_reg, out_valid_next;
    logic             keep_reg, keep_next;
    logic             ovf_reg, ovf_next;

    token_t           tok [CHAIN_LEN+1];
    cell_ctrl_t       ctrl [CHAIN_LEN];
    logic [CHAIN_LEN:0] live_vec;

    logic accept, adv, consume, end_keep, full, store_wr;

    assign accept   = box_in.valid && box_in.ready;
    assign box_in.ready = (state_reg == ST_IDLE);
    assign adv      = !(tok[CHAIN_LEN].live && out_valid_reg && !result.ready);
    assign consume  = tok[CHAIN_LEN].live && adv;
    assign end_keep = !tok[CHAIN_LEN].sup;
    assign full     = (count_reg == CNT_W'(MAX_KEPT));
    assign store_wr = consume && end_keep && !full;

    assign tok[0] = entry_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_LEN; gi++)
        begin : g_cell
            if (gi < MAX_KEPT)
            begin : g_store
                assign ctrl[gi].cmp_en = (CNT_W'(gi) < count_reg);
                assign ctrl[gi].load   = store_wr && (count_reg == CNT_W'(gi));
            end
            else
            begin : g_tail
                assign ctrl[gi] = '0;
            end

            gbs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .ctrl      (ctrl[gi]),
                .load_box  (tok[CHAIN_LEN].cand),
                .load_area (tok[CHAIN_LEN].cand_area),
                .thr       (thr_reg),
                .tok_in    (tok[gi]),
                .tok_out   (tok[gi+1])
            );
        end

        for (gi = 0; gi <= CHAIN_LEN; gi++)
        begin : g_live
            assign live_vec[gi] = tok[gi].live;
        end
    endgenerate

    always_comb
    begin
        entry_next = entry_reg;
        if (accept)
        begin
            entry_next                = '0;
            entry_next.live           = 1'b1;
            entry_next.cand.left      = box_in.box_left;
            entry_next.cand.top       = box_in.box_top;
            entry_next.cand.width     = box_in.box_width;
            entry_next.cand.height    = box_in.box_height;
            entry_next.cand_area      = {{DIM_W{1'b0}}, box_in.box_width}
                                      * {{DIM_W{1'b0}}, box_in.box_height};
        end
        else if (adv)
        begin
            entry_next.live = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    if (box_in.set_start)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (consume)
                begin
                    state_next = ST_IDLE;
                    if (store_wr)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        keep_next      = keep_reg;
        ovf_next       = ovf_reg;
        priority if (consume)
        begin
            out_valid_next = 1'b1;
            keep_next      = end_keep;
            ovf_next       = end_keep && full;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            thr_reg       <= THR_RESET;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            entry_reg     <= entry_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.iou_threshold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg <= keep_next;
        ovf_reg  <= ovf_next;
    end

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.keep           = keep_reg;
    assign result.store_overflow = ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count exceeds store depth");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(live_vec) <= 1)
        else $error("more than one box in the cell chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (live_vec == '0))
        else $error("box in the chain while idle");

    a_consume_run: assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("finished box did not reach the result register");

    a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> keep_reg)
        else $error("overflow reported on a suppressed box");
`endif

endmodule

// ----- tb/greedy_box_suppression_core_test.sv -----
// ============================================================================
// greedy_box_suppression_core_test: self-checking bench for the box suppressor
// Drives boxes with random gaps, stalls the result channel, rewrites the IoU
// threshold between phases and compares every keep/overflow verdict against a
// behavioral predictor of the greedy suppression store.
// ============================================================================
module greedy_box_suppression_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_BOXES  = 225;
    localparam int DRAIN_CYCLES = 75;

    // Predicts the verdict of each accepted box and checks the results in order.
    class suppression_scoreboard;
        logic [THR_W-1:0]  threshold;
        box_t              kept_box [MAX_KEPT];
        logic [AREA_W-1:0] kept_area [MAX_KEPT];
        int                kept_n;
        logic [1:0]        verdicts [$];
        int                errors;
        int                boxes;
        int                n_keep;
        int                n_drop;
        int                n_full;
        int                settings;

        function new();
            threshold = THR_RESET;
            kept_n    = 0;
            errors    = 0;
            boxes     = 0;
            n_keep    = 0;
            n_drop    = 0;
            n_full    = 0;
            settings  = 0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
            settings++;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void note_box(logic first, box_t b);
            int                bl, bt, br, bb, kl, kt, kr, kb, lx, ly, hx, hy, i;
            int                bw, bh, kw, kh;
            longint unsigned   ov, un;
            logic [AREA_W-1:0] area;
            logic              survive;
            logic              full;
            logic [1:0]        verdict;
            boxes++;
            if (first)
            begin
                kept_n = 0;
            end
            bl = int'($signed(b.left));
            bt = int'($signed(b.top));
            bw = int'(b.width);
            bh = int'(b.height);
            br = bl + bw;
            bb = bt + bh;
            area = AREA_W'(b.width) * AREA_W'(b.height);
            survive = 1'b1;
            full = 1'b0;
            for (i = 0; i < kept_n; i++)
            begin
                kl = int'($signed(kept_box[i].left));
                kt = int'($signed(kept_box[i].top));
                kw = int'(kept_box[i].width);
                kh = int'(kept_box[i].height);
                kr = kl + kw;
                kb = kt + kh;
                lx = (bl > kl) ? bl : kl;
                ly = (bt > kt) ? bt : kt;
                hx = (br < kr) ? br : kr;
                hy = (bb < kb) ? bb : kb;
                if (hx - lx <= 0 || hy - ly <= 0)
                begin
                    ov = '0;
                end
                else
                begin
                    ov = 64'((hx - lx) * (hy - ly));
                end
                un = area + kept_area[i] - ov;
                // Division-free IoU test; a zero union can never suppress.
                if (ov * 64'd65536 > threshold * un)
                begin
                    survive = 1'b0;
                end
            end
            if (survive)
            begin
                if (kept_n < MAX_KEPT)
                begin
                    kept_box[kept_n]  = b;
                    kept_area[kept_n] = area;
                    kept_n++;
                end
                else
                begin
                    full = 1'b1;
                end
            end
            verdict = {survive, full};
            verdicts.insert(verdicts.size(), verdict);
        endfunction

        function void check_result(logic keep, logic store_overflow);
            logic [1:0] want;
            if (verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: result keep=%0b store_overflow=%0b with no box outstanding",
                         $time, keep, store_overflow);
                return;
            end
            want = verdicts.pop_front();
            if (keep !== want[1])
            begin
                errors++;
                $display("%0t: keep mismatch, expected %0b, actual %0b",
                         $time, want[1], keep);
            end
            if (store_overflow !== want[0])
            begin
                errors++;
                $display("%0t: store_overflow mismatch, expected %0b, actual %0b",
                         $time, want[0], store_overflow);
            end
            if (want[1])
            begin
                n_keep++;
            end
            else
            begin
                n_drop++;
            end
            if (want[0])
            begin
                n_full++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm = 1'b0;
    int   hold_cnt = 0;
    int   cycles = 0;

    suppression_scoreboard sb;

    gbs_box_if box_if ();
    gbs_res_if res_if ();
    gbs_cfg_if cfg_if ();

    greedy_box_suppression_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .box_in (box_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result channel back-pressure: mostly short stalls, now and then a long one
    // so that a second result can catch up with one still waiting.
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            res_if.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(99) < 4)
        begin
            hold_cnt <= ($urandom_range(39) == 0) ? $urandom_range(160, 70) : $urandom_range(3);
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    // Transaction monitor for all three channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                sb.set_threshold(cfg_if.iou_threshold);
            end
            if (box_if.valid && box_if.ready)
            begin
                sb.note_box(box_if.set_start, '{box_if.box_left, box_if.box_top,
                                                box_if.box_width, box_if.box_height});
            end
            if (res_if.valid && res_if.ready)
            begin
                sb.check_result(res_if.keep, res_if.store_overflow);
            end
        end
    end

    function automatic box_t mk_box(int l, int t, int w, int h);
        box_t b;
        b.left   = COORD_W'(l);
        b.top    = COORD_W'(t);
        b.width  = DIM_W'(w);
        b.height = DIM_W'(h);
        return b;
    endfunction

    task automatic push_box(input logic first, input box_t b);
        int gap;
        if (!calm && $urandom_range(99) < 19)
        begin
            gap = ($urandom_range(19) == 0) ? $urandom_range(140, 20) : $urandom_range(4, 1);
            box_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_if.valid      <= 1'b1;
        box_if.set_start  <= first;
        box_if.box_left   <= b.left;
        box_if.box_top    <= b.top;
        box_if.box_width  <= b.width;
        box_if.box_height <= b.height;
        @(posedge clk);
        while (!box_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    // The block is idle once every box has produced its result.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        box_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        cfg_if.valid         <= 1'b1;
        cfg_if.iou_threshold <= value;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Random sets: overlapping clusters, long disjoint grids that fill the store,
    // degenerate zero-area boxes, and full-range noise.
    task automatic run_phase(input int quota);
        int   sent, n, kind, cx, cy, k, jx, jy, w, h;
        logic first;
        box_t b;
        sent = 0;
        b = mk_box(0, 0, 0, 0);
        while (sent < quota)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                n = $urandom_range(30, 3);
            end
            else if (kind < 65)
            begin
                n = $urandom_range(80, 50);
            end
            else if (kind < 80)
            begin
                n = $urandom_range(72, 5);
            end
            else
            begin
                n = $urandom_range(12, 1);
            end
            cx = $urandom_range(7800);
            cx = cx - 3900;
            cy = $urandom_range(7800);
            cy = cy - 3900;
            for (k = 0; k < n && sent < quota; k++)
            begin
                jx = $urandom_range(80);
                jy = $urandom_range(80);
                if (kind < 45)
                begin
                    w = $urandom_range(80, 1);
                    h = $urandom_range(80, 1);
                    b = mk_box(cx + jx - 40, cy + jy - 40, w, h);
                end
                else if (kind < 65)
                begin
                    // Repeating the previous box now and then gives a suppression.
                    if (k == 0 || $urandom_range(9) != 0)
                    begin
                        w = $urandom_range(400, 1);
                        h = $urandom_range(400, 1);
                        b = mk_box(-4000 + (k % 16) * 480 + jx / 4,
                                   -4000 + (k / 16) * 480 + jy / 4, w, h);
                    end
                end
                else if (kind < 80)
                begin
                    w = ($urandom_range(1) == 0) ? 0 : $urandom_range(6);
                    h = (w != 0 && $urandom_range(3) != 0) ? 0 : $urandom_range(6);
                    b = mk_box(cx + jx / 4 - 10, cy + jy / 4 - 10, w, h);
                end
                else
                begin
                    b = mk_box($urandom_range(8191), $urandom_range(8191),
                               $urandom_range(4095), $urandom_range(4095));
                end
                if (k == 0)
                begin
                    first = ($urandom_range(19) != 0);
                end
                else
                begin
                    first = ($urandom_range(49) == 0);
                end
                push_box(first, b);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] thr_plan [6];
        int               p;
        sb = new();
        rst_n                <= 1'b0;
        box_if.valid         <= 1'b0;
        box_if.set_start     <= 1'b0;
        box_if.box_left      <= '0;
        box_if.box_top       <= '0;
        box_if.box_width     <= '0;
        box_if.box_height    <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.iou_threshold <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: coordinate extremes, touching edges, zero-area boxes
        // and a pair that lands just above and just below the threshold.
        push_box(1'b1, mk_box(-4096, -4096, 4095, 4095));
        push_box(1'b0, mk_box(-4096, -4096, 4095, 4095));
        push_box(1'b0, mk_box(4095, 4095, 4095, 4095));
        push_box(1'b0, mk_box(-1, 0, 10, 10));
        push_box(1'b1, mk_box(0, 0, 0, 0));
        push_box(1'b0, mk_box(0, 0, 0, 0));
        push_box(1'b0, mk_box(0, -5, 0, 4095));
        push_box(1'b1, mk_box(0, 0, 100, 100));
        push_box(1'b0, mk_box(0, 0, 100, 20));
        push_box(1'b0, mk_box(0, 0, 100, 19));
        push_box(1'b0, mk_box(-50, -50, 100, 100));

        // A zero threshold suppresses on any overlap at all.
        write_threshold(16'h0000);
        push_box(1'b1, mk_box(10, 10, 5, 5));
        push_box(1'b0, mk_box(14, 14, 5, 5));
        push_box(1'b0, mk_box(15, 10, 5, 5));

        // The largest threshold suppresses only an exact duplicate.
        write_threshold(16'hFFFF);
        push_box(1'b1, mk_box(0, 0, 50, 50));
        push_box(1'b0, mk_box(0, 0, 50, 50));
        push_box(1'b0, mk_box(0, 0, 50, 49));
        push_box(1'b0, mk_box(-4096, 4095, 4095, 0));

        thr_plan[0] = 16'h0001;
        thr_plan[1] = THR_W'($urandom_range(65535));
        thr_plan[2] = 16'hFFFF;
        thr_plan[3] = 16'h8000;
        thr_plan[4] = 16'h0000;
        thr_plan[5] = THR_W'($urandom_range(30000, 4000));
        for (p = 0; p < 6; p++)
        begin
            write_threshold(thr_plan[p]);
            calm <= (p == 2);
            run_phase(PHASE_BOXES);
        end
        calm <= 1'b0;

        box_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d boxes under %0d threshold settings besides the reset value.",
                 sb.boxes, sb.settings);
        $display("Verdicts: %0d kept, %0d suppressed, %0d kept with the store full.",
                 sb.n_keep, sb.n_drop, sb.n_full);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gbs_pkg.sv
hdl/gbs_ifs.sv
hdl/gbs_cell.sv
hdl/greedy_box_suppression_core.sv
tb/greedy_box_suppression_core_test.sv
